// ===== sv/sensor_mean_accumulator_core_defines.svh =====
// ----------------------------------------------------------------------------
// Sensor mean accumulator assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SENSOR_MEAN_ACCUMULATOR_CORE_DEFINES_SVH
`define SENSOR_MEAN_ACCUMULATOR_CORE_DEFINES_SVH

// Same-cycle implication: when ante holds, cons must hold on the same edge.
`define SMAC_ASSERT_SAME(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("smac assertion failed");

// Next-cycle implication: when ante holds, cons must hold on the following edge.
`define SMAC_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("smac assertion failed");

`endif

// ===== sv/smac_pkg.sv =====
// ----------------------------------------------------------------------------
// Sensor mean accumulator package
// Widths, codes, state and command types and the accumulate helper.
// ----------------------------------------------------------------------------
package smac_pkg;

   // Field widths.
   localparam int unsigned SAMPLE_W   = 10;
   localparam int unsigned CHAN_W     = 4;
   localparam int unsigned WHICH_W    = 3;
   localparam int unsigned VALUE_W    = 16;
   localparam int unsigned COUNT_W    = 16;
   localparam int unsigned SUM_W      = 32;
   localparam int unsigned RSUM_W     = 17;
   localparam int unsigned SCHED_W    = 4;
   localparam int unsigned NUM_ANALOG = 3;
   localparam int unsigned ANALOG_IDX_W = 2;

   // Divider geometry: 48-bit dividend, 24-bit divisor, 16 quotient bits.
   localparam int unsigned DVD_W    = 48;
   localparam int unsigned DVS_W    = 24;
   localparam int unsigned STEP_W   = 4;
   localparam int unsigned MV_SHIFT = 8;
   localparam int unsigned PROD_W   = 41;

   // Stream packing.
   localparam int unsigned REQ_DATA_W = 24;
   localparam int unsigned RSP_DATA_W = 24;

   // Configuration port.
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic        CSR_IDX_TARGET_RAW = 1'b0;

   // Arithmetic constants.
   localparam logic [SUM_W-1:0]    ANALOG_LIMIT = 32'd15617038;
   localparam logic [SUM_W-1:0]    RATIO_LIMIT  = 32'd65534;
   localparam logic [SUM_W-1:0]    ANALOG_MASK  = 32'hFFFF_FFFF;
   localparam logic [SUM_W-1:0]    RATIO_MASK   = 32'h0001_FFFF;
   localparam logic [COUNT_W-1:0]  HALF_COUNT   = 16'h8000;
   localparam logic [8:0]          MV_NUM       = 9'd275;
   localparam logic [SAMPLE_W-1:0] TARGET_RESET = 10'd930;

   // Action codes.
   localparam logic ACTION_SAMPLE = 1'b0;
   localparam logic ACTION_TAKE   = 1'b1;

   // Channel codes.
   localparam logic [CHAN_W-1:0] CHAN_K5       = 4'd0;
   localparam logic [CHAN_W-1:0] CHAN_PEAK     = 4'd2;
   localparam logic [CHAN_W-1:0] CHAN_OUTSIDE  = 4'd3;
   localparam logic [CHAN_W-1:0] CHAN_TANK     = 4'd4;
   localparam logic [CHAN_W-1:0] CHAN_INTERNAL = 4'd8;

   // Schedule positions that name a non-default channel.
   localparam logic [SCHED_W-1:0] POS_INTERNAL = 4'd0;
   localparam logic [SCHED_W-1:0] POS_PEAK     = 4'd4;
   localparam logic [SCHED_W-1:0] POS_OUTSIDE  = 4'd8;
   localparam logic [SCHED_W-1:0] POS_TANK     = 4'd12;

   // Take selector codes.
   typedef enum logic [WHICH_W-1:0] {
      TAKE_K5      = 3'd0,
      TAKE_RATIO   = 3'd1,
      TAKE_OUTSIDE = 3'd2,
      TAKE_TANK    = 3'd3,
      TAKE_PEAK    = 3'd4
   } take_sel_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SAMPLE,
      ST_TAKE,
      ST_DIV_CHECK,
      ST_DIV_RUN,
      ST_FINISH
   } state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic capture;
      logic sample;
      logic take;
      logic div_check;
      logic div_step;
      logic out_load;
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic need_div;
      logic div_ovf;
      logic out_free;
   } status_type;

   // One sum/count pair.
   typedef struct packed {
      logic [SUM_W-1:0]   sum;
      logic [COUNT_W-1:0] count;
   } acc_type;

   // Add one value; halve on count wrap, or on an even count over the limit.
   function automatic acc_type accumulate(input logic [SUM_W-1:0] sum,
                                          input logic [COUNT_W-1:0] count,
                                          input logic [SUM_W-1:0] val,
                                          input logic [SUM_W-1:0] limit,
                                          input logic [SUM_W-1:0] mask);
      acc_type r;
      r.sum   = (sum + val) & mask;
      r.count = count + 16'd1;
      if (r.count == '0) begin
         r.sum   = r.sum >> 1;
         r.count = HALF_COUNT;
      end else if (!r.count[0] && (r.sum > limit)) begin
         r.sum   = r.sum >> 1;
         r.count = r.count >> 1;
      end
      return r;
   endfunction

   // Channel scheduled for the next conversion at a schedule position.
   function automatic logic [CHAN_W-1:0] next_channel(input logic [SCHED_W-1:0] pos);
      logic [CHAN_W-1:0] ch;
      case (pos)
         POS_INTERNAL: ch = CHAN_INTERNAL;
         POS_PEAK:     ch = CHAN_PEAK;
         POS_OUTSIDE:  ch = CHAN_OUTSIDE;
         POS_TANK:     ch = CHAN_TANK;
         default:      ch = CHAN_K5;
      endcase
      return ch;
   endfunction

endpackage

// ===== sv/sensor_mean_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// Sensor mean accumulator core
// Accumulates converter samples per channel and answers mean, ratio and peak
// take requests over a stream interface, with an APB-style register port.
// ----------------------------------------------------------------------------
// Usage: each req word is either a sample (req_tuser = 0) or a take request
// (req_tuser = 1). Every accepted word yields exactly one rsp word, in order.
// A sample updates the pulldown flag, the mean and ratio accumulators, the
// peak hold and the conversion schedule; its rsp word carries the next
// channel. A take returns and clears the selected accumulator.
// The block works on one word at a time. A sample passes through the sample
// and finish states. An empty, peak or unknown take goes from the take state
// to finish; a mean or ratio take with samples passes a divide check that
// saturates the quotient or runs the restoring divider, one quotient bit per
// cycle, before finish. rsp_tvalid rises as finish loads the result.
// req_tready is high only when the block is idle, which is from the cycle
// after the result is loaded. A finished rsp word is held in an output
// register, so a new word may be accepted while it waits. If the receiver
// stalls, the next result waits in finish until the output register frees.
// Reset (synchronous, active high) clears all accumulators, the peak, the
// flag and the schedule, and sets target_raw to 930.
// ----------------------------------------------------------------------------
`include "sensor_mean_accumulator_core_defines.svh"

module sensor_mean_accumulator_core (
   input  logic                                clock,
   input  logic                                reset,
   // Request stream.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [smac_pkg::REQ_DATA_W-1:0]     req_tdata,  // sample[9:0], sample_channel[13:10], take_which[16:14]
   input  logic                                req_tuser,  // action
   // Response stream.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [smac_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // next_channel[3:0], pull_down[4], result_value[20:5]
   output logic                                rsp_tuser,  // result_empty
   // Register port.
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [smac_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [smac_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [smac_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   logic [smac_pkg::SAMPLE_W-1:0]  target_ff, target_in;
   logic                           csr_wr;
   smac_pkg::cmd_type              cmd;
   smac_pkg::status_type           st;
   logic [smac_pkg::CHAN_W-1:0]    out_next;
   logic                           out_pull;
   logic [smac_pkg::VALUE_W-1:0]   out_value;
   logic                           out_empty;

   // Register port: single register target_raw, decoded at every address with paddr[2] clear.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      target_in = target_ff;
      if (csr_wr && (csr_paddr[2] == smac_pkg::CSR_IDX_TARGET_RAW)) begin
         target_in = csr_pwdata[smac_pkg::SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= smac_pkg::TARGET_RESET;
      end else begin
         target_ff <= target_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == smac_pkg::CSR_IDX_TARGET_RAW) ?
                       {22'd0, target_ff} : '0;

   // Controller.
   smac_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_action (req_tuser),
      .st         (st),
      .cmd        (cmd),
      .req_ready  (req_tready)
   );

   // Datapath.
   smac_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .st               (st),
      .target_raw       (target_ff),
      .in_sample        (req_tdata[9:0]),
      .in_chan          (req_tdata[13:10]),
      .in_which         (req_tdata[16:14]),
      .out_ready        (rsp_tready),
      .out_valid        (rsp_tvalid),
      .out_next_channel (out_next),
      .out_pull_down    (out_pull),
      .out_value        (out_value),
      .out_empty        (out_empty)
   );

   assign rsp_tdata = {3'd0, out_value, out_pull, out_next};
   assign rsp_tuser = out_empty;

   // One word at a time: acceptance closes the request side.
   `SMAC_ASSERT_NEXT(a_one_in_flight, req_tvalid && req_tready, !req_tready)

   // An empty take always reports a zero value.
   `SMAC_ASSERT_SAME(a_empty_zero, rsp_tvalid && rsp_tuser, out_value == '0)

   // A word naming a next channel is a sample result: zero value, never empty.
   `SMAC_ASSERT_SAME(a_sample_result, rsp_tvalid && (out_next != '0),
                     (out_value == '0) && !rsp_tuser)

   // A register write to an address with paddr[2] clear lands in target_raw.
   `SMAC_ASSERT_NEXT(a_csr_write, csr_wr && (csr_paddr[2] == smac_pkg::CSR_IDX_TARGET_RAW),
                     target_ff == $past(csr_pwdata[smac_pkg::SAMPLE_W-1:0]))

endmodule

// ===== sv/smac_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sensor mean accumulator controller
// Sequences one word at a time: sample commit, or take with optional divide.
// ----------------------------------------------------------------------------
module smac_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_action,
   input  smac_pkg::status_type  st,
   output smac_pkg::cmd_type     cmd,
   output logic                  req_ready
);

   smac_pkg::state_type           state_ff, state_in;
   logic [smac_pkg::STEP_W-1:0]   step_ff, step_in;

   // State and divide step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= smac_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         smac_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = (req_action == smac_pkg::ACTION_TAKE) ?
                             smac_pkg::ST_TAKE : smac_pkg::ST_SAMPLE;
            end
         end
         smac_pkg::ST_SAMPLE: begin
            cmd.sample = 1'b1;
            state_in   = smac_pkg::ST_FINISH;
         end
         smac_pkg::ST_TAKE: begin
            cmd.take = 1'b1;
            state_in = st.need_div ? smac_pkg::ST_DIV_CHECK : smac_pkg::ST_FINISH;
         end
         smac_pkg::ST_DIV_CHECK: begin
            cmd.div_check = 1'b1;
            step_in       = '0;
            state_in      = st.div_ovf ? smac_pkg::ST_FINISH : smac_pkg::ST_DIV_RUN;
         end
         smac_pkg::ST_DIV_RUN: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == '1) begin
               state_in = smac_pkg::ST_FINISH;
            end
         end
         smac_pkg::ST_FINISH: begin
            if (st.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = smac_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = smac_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/smac_dp.sv =====
// ----------------------------------------------------------------------------
// Sensor mean accumulator datapath
// Accumulators, peak hold, schedule, restoring divider and result register.
// ----------------------------------------------------------------------------
module smac_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  smac_pkg::cmd_type                   cmd,
   output smac_pkg::status_type                st,
   input  logic [smac_pkg::SAMPLE_W-1:0]       target_raw,
   input  logic [smac_pkg::SAMPLE_W-1:0]       in_sample,
   input  logic [smac_pkg::CHAN_W-1:0]         in_chan,
   input  logic [smac_pkg::WHICH_W-1:0]        in_which,
   input  logic                                out_ready,
   output logic                                out_valid,
   output logic [smac_pkg::CHAN_W-1:0]         out_next_channel,
   output logic                                out_pull_down,
   output logic [smac_pkg::VALUE_W-1:0]        out_value,
   output logic                                out_empty
);

   // Latched input word.
   logic [smac_pkg::SAMPLE_W-1:0]  it_sample_ff;
   logic [smac_pkg::CHAN_W-1:0]    it_chan_ff;
   logic [smac_pkg::WHICH_W-1:0]   it_which_ff;

   // Accumulator state.
   logic [smac_pkg::SUM_W-1:0]     sums_ff   [smac_pkg::NUM_ANALOG];
   logic [smac_pkg::SUM_W-1:0]     sums_in   [smac_pkg::NUM_ANALOG];
   logic [smac_pkg::COUNT_W-1:0]   counts_ff [smac_pkg::NUM_ANALOG];
   logic [smac_pkg::COUNT_W-1:0]   counts_in [smac_pkg::NUM_ANALOG];
   logic [smac_pkg::RSUM_W-1:0]    rsum_ff, rsum_in;
   logic [smac_pkg::COUNT_W-1:0]   rcount_ff, rcount_in;
   logic [smac_pkg::SAMPLE_W-1:0]  peak_ff, peak_in;
   logic                           flag_ff, flag_in;
   logic [smac_pkg::SCHED_W-1:0]   pos_ff, pos_in;

   // Result being built.
   logic [smac_pkg::VALUE_W-1:0]   res_value_ff, res_value_in;
   logic                           res_empty_ff, res_empty_in;
   logic [smac_pkg::CHAN_W-1:0]    res_next_ff, res_next_in;

   // Divider.
   logic [smac_pkg::DVD_W-1:0]     x_ff, x_in;
   logic [smac_pkg::DVS_W-1:0]     d_ff, d_in;
   logic [smac_pkg::DVS_W-1:0]     rem_ff, rem_in;

   // Output register.
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [smac_pkg::CHAN_W-1:0]    rsp_next_ff;
   logic                           rsp_pull_ff;
   logic [smac_pkg::VALUE_W-1:0]   rsp_value_ff;
   logic                           rsp_empty_ff;

   // Helpers.
   logic                           analog_hit;
   logic [smac_pkg::ANALOG_IDX_W-1:0] s_idx;
   logic                           take_analog;
   logic [smac_pkg::ANALOG_IDX_W-1:0] t_idx;
   logic [smac_pkg::PROD_W-1:0]    prod;
   logic                           ovf;
   logic [smac_pkg::DVS_W:0]       trial;
   logic                           trial_ge;
   logic                           flag_new;
   smac_pkg::acc_type              acc_a, acc_r;
   logic [smac_pkg::SCHED_W-1:0]   pos_next;

   // Map the sample channel onto an analog accumulator.
   always_comb begin
      analog_hit = 1'b1;
      s_idx      = '0;
      case (it_chan_ff)
         smac_pkg::CHAN_K5:      s_idx = 2'd0;
         smac_pkg::CHAN_OUTSIDE: s_idx = 2'd1;
         smac_pkg::CHAN_TANK:    s_idx = 2'd2;
         default:                analog_hit = 1'b0;
      endcase
   end

   // Map the take selector onto an analog accumulator.
   always_comb begin
      take_analog = 1'b1;
      t_idx       = '0;
      case (smac_pkg::take_sel_type'(it_which_ff))
         smac_pkg::TAKE_K5:      t_idx = 2'd0;
         smac_pkg::TAKE_OUTSIDE: t_idx = 2'd1;
         smac_pkg::TAKE_TANK:    t_idx = 2'd2;
         default:                take_analog = 1'b0;
      endcase
   end

   // Sample commit arithmetic.
   assign flag_new = (it_chan_ff == smac_pkg::CHAN_K5) ? (it_sample_ff > target_raw) : flag_ff;
   assign acc_a = smac_pkg::accumulate(sums_ff[s_idx], counts_ff[s_idx],
                                       {22'd0, it_sample_ff},
                                       smac_pkg::ANALOG_LIMIT, smac_pkg::ANALOG_MASK);
   assign acc_r = smac_pkg::accumulate({15'd0, rsum_ff}, rcount_ff, {31'd0, flag_new},
                                       smac_pkg::RATIO_LIMIT, smac_pkg::RATIO_MASK);
   assign pos_next = pos_ff + 1'b1;

   // Mean numerator: sum times the millivolt scale.
   assign prod = smac_pkg::PROD_W'(sums_ff[t_idx]) * smac_pkg::PROD_W'(smac_pkg::MV_NUM);

   // Quotient overflows 16 bits when the dividend's upper part reaches the divisor.
   assign ovf = x_ff[smac_pkg::DVD_W-1:smac_pkg::VALUE_W] >= {8'd0, d_ff};

   // One restoring step: bring down the next dividend bit.
   assign trial    = {rem_ff, x_ff[smac_pkg::VALUE_W-1]};
   assign trial_ge = trial >= {1'b0, d_ff};

   // Status to the controller.
   always_comb begin
      st.need_div = 1'b0;
      if (take_analog) begin
         st.need_div = (counts_ff[t_idx] != '0);
      end else if (smac_pkg::take_sel_type'(it_which_ff) == smac_pkg::TAKE_RATIO) begin
         st.need_div = (rcount_ff != '0);
      end
      st.div_ovf  = ovf;
      st.out_free = !rsp_valid_ff || out_ready;
   end

   // Next-state logic of the datapath registers.
   always_comb begin
      for (int i = 0; i < smac_pkg::NUM_ANALOG; i++) begin
         sums_in[i]   = sums_ff[i];
         counts_in[i] = counts_ff[i];
      end
      rsum_in      = rsum_ff;
      rcount_in    = rcount_ff;
      peak_in      = peak_ff;
      flag_in      = flag_ff;
      pos_in       = pos_ff;
      res_value_in = res_value_ff;
      res_empty_in = res_empty_ff;
      res_next_in  = res_next_ff;
      x_in         = x_ff;
      d_in         = d_ff;
      rem_in       = rem_ff;

      if (cmd.sample) begin
         flag_in = flag_new;
         if (analog_hit) begin
            sums_in[s_idx]   = acc_a.sum;
            counts_in[s_idx] = acc_a.count;
         end
         if ((it_chan_ff == smac_pkg::CHAN_PEAK) && (it_sample_ff > peak_ff)) begin
            peak_in = it_sample_ff;
         end
         rsum_in      = acc_r.sum[smac_pkg::RSUM_W-1:0];
         rcount_in    = acc_r.count;
         pos_in       = pos_next;
         res_next_in  = smac_pkg::next_channel(pos_next);
         res_value_in = '0;
         res_empty_in = 1'b0;
      end

      // Take: read and clear the selected store, set up the divider.
      if (cmd.take) begin
         res_next_in  = '0;
         res_value_in = '0;
         res_empty_in = 1'b0;
         if (take_analog) begin
            res_empty_in     = (counts_ff[t_idx] == '0);
            x_in             = {7'd0, prod};
            d_in             = {counts_ff[t_idx], 8'd0};
            sums_in[t_idx]   = '0;
            counts_in[t_idx] = '0;
         end else begin
            case (smac_pkg::take_sel_type'(it_which_ff))
               smac_pkg::TAKE_RATIO: begin
                  res_empty_in = (rcount_ff == '0);
                  x_in         = {15'd0, rsum_ff, 16'd0};
                  d_in         = {8'd0, rcount_ff};
                  rsum_in      = '0;
                  rcount_in    = '0;
               end
               smac_pkg::TAKE_PEAK: begin
                  res_value_in = {6'd0, peak_ff};
                  peak_in      = '0;
               end
               default: begin
                  res_value_in = '0;
               end
            endcase
         end
      end

      // Overflow saturates; otherwise seed the partial remainder.
      if (cmd.div_check) begin
         if (ovf) begin
            res_value_in = '1;
         end else begin
            rem_in = x_ff[smac_pkg::DVS_W+smac_pkg::VALUE_W-1:smac_pkg::VALUE_W];
         end
      end

      // Shift in one quotient bit per cycle.
      if (cmd.div_step) begin
         rem_in       = trial_ge ? smac_pkg::DVS_W'(trial - {1'b0, d_ff}) :
                                   trial[smac_pkg::DVS_W-1:0];
         res_value_in = {res_value_ff[smac_pkg::VALUE_W-2:0], trial_ge};
         x_in         = {x_ff[smac_pkg::DVD_W-1:smac_pkg::VALUE_W],
                         x_ff[smac_pkg::VALUE_W-2:0], 1'b0};
      end
   end

   // Output valid: set on load, cleared when the word is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && out_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Architectural state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < smac_pkg::NUM_ANALOG; i++) begin
            sums_ff[i]   <= '0;
            counts_ff[i] <= '0;
         end
         rsum_ff      <= '0;
         rcount_ff    <= '0;
         peak_ff      <= '0;
         flag_ff      <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < smac_pkg::NUM_ANALOG; i++) begin
            sums_ff[i]   <= sums_in[i];
            counts_ff[i] <= counts_in[i];
         end
         rsum_ff      <= rsum_in;
         rcount_ff    <= rcount_in;
         peak_ff      <= peak_in;
         flag_ff      <= flag_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         it_sample_ff <= in_sample;
         it_chan_ff   <= in_chan;
         it_which_ff  <= in_which;
      end
      res_value_ff <= res_value_in;
      res_empty_ff <= res_empty_in;
      res_next_ff  <= res_next_in;
      x_ff         <= x_in;
      d_ff         <= d_in;
      rem_ff       <= rem_in;
      if (cmd.out_load) begin
         rsp_next_ff  <= res_next_ff;
         rsp_pull_ff  <= flag_ff;
         rsp_value_ff <= res_value_ff;
         rsp_empty_ff <= res_empty_ff;
      end
   end

   assign out_valid        = rsp_valid_ff;
   assign out_next_channel = rsp_next_ff;
   assign out_pull_down    = rsp_pull_ff;
   assign out_value        = rsp_value_ff;
   assign out_empty        = rsp_empty_ff;

endmodule
